>>> rtl/hsv_pkg.sv
// HSV to RGB converter: shared types and fixed constants.
// Used by every module of the block; depends on nothing.
package hsv_pkg;

    localparam int HUE_W    = 20;        // signed hue, 1/16 degree
    localparam int Q12_W    = 13;        // saturation / brightness width
    localparam int CHAN_W   = 8;         // output channel width
    localparam int PROD_W   = 25;        // V*S and V*(1-S), at most 2^24
    localparam int NUM_W    = 34;        // channel numerator, at most 960*2^24
    localparam int FRAC_W   = 10;        // position inside a sector, 0..959
    localparam int COARSE_W = 15;        // hue offset in units of 64

    localparam int Q_ONE       = 4096;
    localparam int HUE_OFFSET  = 529920; // 92 turns of 5760, lifts hue above zero
    localparam int TURN_COARSE = 90;     // 5760 / 64
    localparam int ROW_COARSE  = 15;     // 960 / 64
    localparam int RECIP_TURN  = 1456;   // just under 2^17 / 90
    localparam int RECIP_SHIFT = 17;
    localparam int SECTOR_SPAN = 960;
    localparam int SCALE_SHIFT = 30;     // 255 / (960 * 2^24) = 17 / 2^30

    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } t_sector;

    typedef struct packed {
        t_sector             sector;
        logic [FRAC_W-1:0]   frac;   // position inside the sector
        logic [PROD_W-1:0]   vs;     // V*S
        logic [PROD_W-1:0]   vns;    // V*(4096-S)
    } t_front;

    typedef struct packed {
        logic [NUM_W-1:0] num_r;
        logic [NUM_W-1:0] num_g;
        logic [NUM_W-1:0] num_b;
    } t_blend;

endpackage

>>> rtl/hsv_front.sv
// HSV front end: hue wrap, sector split, input clamp and V*S products.
// Three register stages; uses hsv_pkg.
module hsv_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hsv_pkg::HUE_W-1:0]    i_hue,
    input  logic [hsv_pkg::Q12_W-1:0]    i_saturation,
    input  logic [hsv_pkg::Q12_W-1:0]    i_brightness,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hsv_pkg::t_front              o_front
);

    logic [2:0] r_vld;
    logic [2:0] w_adv;

    // stage 1
    logic [hsv_pkg::COARSE_W-1:0] r1_coarse;
    logic [5:0]                   r1_low;
    logic [hsv_pkg::Q12_W-1:0]    r1_s;
    logic [hsv_pkg::Q12_W-1:0]    r1_v;
    // stage 2
    logic [hsv_pkg::COARSE_W-1:0] r2_coarse;
    logic [8:0]                   r2_quot;
    logic [5:0]                   r2_low;
    logic [hsv_pkg::PROD_W-1:0]   r2_vs;
    logic [hsv_pkg::PROD_W-1:0]   r2_vns;
    // stage 3
    hsv_pkg::t_front              r3_front;

    logic [20:0]                  w_lift;
    logic [hsv_pkg::Q12_W-1:0]    w_s;
    logic [hsv_pkg::Q12_W-1:0]    w_v;
    logic [25:0]                  w_qm;
    logic [25:0]                  w_vs;
    logic [25:0]                  w_vns;
    logic [hsv_pkg::Q12_W-1:0]    w_ns;
    logic [hsv_pkg::COARSE_W-1:0] w_q90;
    logic [hsv_pkg::COARSE_W-1:0] w_rem;
    logic [6:0]                   w_y;
    logic [6:0]                   w_base;
    logic [6:0]                   w_row;
    hsv_pkg::t_sector             w_sector;

    assign w_adv[2] = !r_vld[2] || i_ready;
    assign w_adv[1] = !r_vld[1] || w_adv[2];
    assign w_adv[0] = !r_vld[0] || w_adv[1];
    assign o_ready  = w_adv[0];
    assign o_valid  = r_vld[2];
    assign o_front  = r3_front;

    // stage 1: lift hue to a positive value, hold S and V to 1.0
    assign w_lift = {i_hue[hsv_pkg::HUE_W-1], i_hue} + 21'(hsv_pkg::HUE_OFFSET);
    assign w_s = (i_saturation > 13'(hsv_pkg::Q_ONE)) ? 13'(hsv_pkg::Q_ONE) : i_saturation;
    assign w_v = (i_brightness > 13'(hsv_pkg::Q_ONE)) ? 13'(hsv_pkg::Q_ONE) : i_brightness;

    // stage 2: estimate turns by reciprocal (never above the true quotient)
    assign w_qm  = {11'd0, r1_coarse} * 26'(hsv_pkg::RECIP_TURN);
    assign w_ns  = 13'(hsv_pkg::Q_ONE) - r1_s;
    assign w_vs  = {13'd0, r1_v} * {13'd0, r1_s};
    assign w_vns = {13'd0, r1_v} * {13'd0, w_ns};

    // stage 3: one correction step, then sector and position
    assign w_q90 = 15'({6'd0, r2_quot} * 15'(hsv_pkg::TURN_COARSE));
    assign w_rem = r2_coarse - w_q90;

    always_comb begin
        if (w_rem >= 15'(hsv_pkg::TURN_COARSE)) begin
            w_y = 7'(w_rem - 15'(hsv_pkg::TURN_COARSE));
        end else begin
            w_y = 7'(w_rem);
        end
        if (w_y >= 7'(5 * hsv_pkg::ROW_COARSE)) begin
            w_sector = hsv_pkg::SEC_MAGENTA_RED;
            w_base   = 7'(5 * hsv_pkg::ROW_COARSE);
        end else if (w_y >= 7'(4 * hsv_pkg::ROW_COARSE)) begin
            w_sector = hsv_pkg::SEC_BLUE_MAGENTA;
            w_base   = 7'(4 * hsv_pkg::ROW_COARSE);
        end else if (w_y >= 7'(3 * hsv_pkg::ROW_COARSE)) begin
            w_sector = hsv_pkg::SEC_CYAN_BLUE;
            w_base   = 7'(3 * hsv_pkg::ROW_COARSE);
        end else if (w_y >= 7'(2 * hsv_pkg::ROW_COARSE)) begin
            w_sector = hsv_pkg::SEC_GREEN_CYAN;
            w_base   = 7'(2 * hsv_pkg::ROW_COARSE);
        end else if (w_y >= 7'(hsv_pkg::ROW_COARSE)) begin
            w_sector = hsv_pkg::SEC_YELLOW_GREEN;
            w_base   = 7'(hsv_pkg::ROW_COARSE);
        end else begin
            w_sector = hsv_pkg::SEC_RED_YELLOW;
            w_base   = 7'd0;
        end
        w_row = w_y - w_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'b000;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_coarse <= w_lift[20:6];
            r1_low    <= w_lift[5:0];
            r1_s      <= w_s;
            r1_v      <= w_v;
        end
        if (w_adv[1]) begin
            r2_coarse <= r1_coarse;
            r2_quot   <= w_qm[25:hsv_pkg::RECIP_SHIFT];
            r2_low    <= r1_low;
            r2_vs     <= w_vs[hsv_pkg::PROD_W-1:0];
            r2_vns    <= w_vns[hsv_pkg::PROD_W-1:0];
        end
        if (w_adv[2]) begin
            r3_front.sector <= w_sector;
            r3_front.frac   <= {w_row[3:0], r2_low};
            r3_front.vs     <= r2_vs;
            r3_front.vns    <= r2_vns;
        end
    end

    // a missed correction step would push the position past the sector end
    a_frac_in_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r3_front.frac < 10'(hsv_pkg::SECTOR_SPAN)))
        else $error("sector position out of range");

endmodule

>>> rtl/hsv_blend.sv
// HSV blend: ramp products and per-sector channel numerators.
// Two register stages; uses hsv_pkg.
module hsv_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hsv_pkg::t_front    i_front,
    output logic               o_valid,
    input  logic               i_ready,
    output hsv_pkg::t_blend    o_blend
);

    logic [1:0] r_vld;
    logic [1:0] w_adv;

    logic [hsv_pkg::NUM_W-1:0]  r_base;   // 960 * V*(1-S), the bottom level
    logic [hsv_pkg::NUM_W-1:0]  r_up;     // f * V*S
    logic [hsv_pkg::NUM_W-1:0]  r_down;   // (960-f) * V*S
    logic [hsv_pkg::NUM_W-1:0]  r_span;   // 960 * V*S
    hsv_pkg::t_sector           r_sector;
    hsv_pkg::t_blend            r_blend;

    logic [34:0]                w_base;
    logic [34:0]                w_up;
    logic [34:0]                w_down;
    logic [34:0]                w_span;
    logic [hsv_pkg::FRAC_W-1:0] w_rest;
    logic [34:0]                w_rise_s;
    logic [34:0]                w_fall_s;
    logic [34:0]                w_top_s;
    logic [hsv_pkg::NUM_W-1:0]  w_rise;
    logic [hsv_pkg::NUM_W-1:0]  w_fall;
    logic [hsv_pkg::NUM_W-1:0]  w_top;
    hsv_pkg::t_blend            w_blend;

    assign w_adv[1] = !r_vld[1] || i_ready;
    assign w_adv[0] = !r_vld[0] || w_adv[1];
    assign o_ready  = w_adv[0];
    assign o_valid  = r_vld[1];
    assign o_blend  = r_blend;

    // 960 = 1024 - 64
    assign w_base = {i_front.vns, 10'd0} - {4'd0, i_front.vns, 6'd0};
    assign w_span = {i_front.vs, 10'd0} - {4'd0, i_front.vs, 6'd0};
    assign w_rest = 10'(hsv_pkg::SECTOR_SPAN) - i_front.frac;
    assign w_up   = {10'd0, i_front.vs} * {25'd0, i_front.frac};
    assign w_down = {10'd0, i_front.vs} * {25'd0, w_rest};

    assign w_rise_s = {1'b0, r_base} + {1'b0, r_up};
    assign w_fall_s = {1'b0, r_base} + {1'b0, r_down};
    assign w_top_s  = {1'b0, r_base} + {1'b0, r_span};
    assign w_rise   = w_rise_s[hsv_pkg::NUM_W-1:0];
    assign w_fall   = w_fall_s[hsv_pkg::NUM_W-1:0];
    assign w_top    = w_top_s[hsv_pkg::NUM_W-1:0];

    always_comb begin
        case (r_sector)
            hsv_pkg::SEC_RED_YELLOW: begin
                w_blend = '{num_r: w_top,  num_g: w_rise, num_b: r_base};
            end
            hsv_pkg::SEC_YELLOW_GREEN: begin
                w_blend = '{num_r: w_fall, num_g: w_top,  num_b: r_base};
            end
            hsv_pkg::SEC_GREEN_CYAN: begin
                w_blend = '{num_r: r_base, num_g: w_top,  num_b: w_rise};
            end
            hsv_pkg::SEC_CYAN_BLUE: begin
                w_blend = '{num_r: r_base, num_g: w_fall, num_b: w_top};
            end
            hsv_pkg::SEC_BLUE_MAGENTA: begin
                w_blend = '{num_r: w_rise, num_g: r_base, num_b: w_top};
            end
            default: begin
                w_blend = '{num_r: w_top,  num_g: r_base, num_b: w_fall};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 2'b00;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_base   <= w_base[hsv_pkg::NUM_W-1:0];
            r_up     <= w_up[hsv_pkg::NUM_W-1:0];
            r_down   <= w_down[hsv_pkg::NUM_W-1:0];
            r_span   <= w_span[hsv_pkg::NUM_W-1:0];
            r_sector <= i_front.sector;
        end
        if (w_adv[1]) begin
            r_blend <= w_blend;
        end
    end

    // the ramp pair always adds up to the full span
    a_ramp_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ({1'b0, r_up} + {1'b0, r_down} == {1'b0, r_span}))
        else $error("ramp products do not cover the span");

endmodule

>>> rtl/hsv_scale.sv
// HSV scale: channel numerators to 8-bit bytes, output register.
// One register stage; uses hsv_pkg.
module hsv_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  hsv_pkg::t_blend               i_blend,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hsv_pkg::CHAN_W-1:0]    o_red,
    output logic [hsv_pkg::CHAN_W-1:0]    o_green,
    output logic [hsv_pkg::CHAN_W-1:0]    o_blue
);

    logic                         r_vld;
    logic                         w_adv;
    logic [hsv_pkg::CHAN_W-1:0]   r_red;
    logic [hsv_pkg::CHAN_W-1:0]   r_green;
    logic [hsv_pkg::CHAN_W-1:0]   r_blue;
    logic [38:0]                  w_pr;
    logic [38:0]                  w_pg;
    logic [38:0]                  w_pb;

    assign w_adv   = !r_vld || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // byte = floor(17 * num / 2^30); 17 * num = num * 16 + num
    assign w_pr = {1'b0, i_blend.num_r, 4'd0} + {5'd0, i_blend.num_r};
    assign w_pg = {1'b0, i_blend.num_g, 4'd0} + {5'd0, i_blend.num_g};
    assign w_pb = {1'b0, i_blend.num_b, 4'd0} + {5'd0, i_blend.num_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_red   <= w_pr[hsv_pkg::SCALE_SHIFT+hsv_pkg::CHAN_W-1:hsv_pkg::SCALE_SHIFT];
            r_green <= w_pg[hsv_pkg::SCALE_SHIFT+hsv_pkg::CHAN_W-1:hsv_pkg::SCALE_SHIFT];
            r_blue  <= w_pb[hsv_pkg::SCALE_SHIFT+hsv_pkg::CHAN_W-1:hsv_pkg::SCALE_SHIFT];
        end
    end

endmodule

>>> rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter, top level: stream ports around a six-stage pipeline.
// Instantiates hsv_front, hsv_blend and hsv_scale; uses hsv_pkg.
//
// Usage:
//   Slave channel takes one pixel word per handshake: signed hue in 1/16
//   degree (wrapped modulo 360 degrees), saturation and brightness as Q12
//   fractions (4096 = 1.0, larger values hold at 1.0).
//   Master channel gives one word per pixel: floor(255 * channel) for red,
//   green and blue, in the order the pixels arrived.
//   Path: an accepted input word passes all six register stages before it
//   reaches o_m_axis_tvalid. Throughput: one word per cycle unless the
//   receiver stalls, set by the six register stages (hue wrap and clamp,
//   reciprocal and V*S products, sector split, ramp products, channel
//   select, byte scaling), each of which can take a new word every cycle.
//   Reset: synchronous, active low; clears all stage valid bits, so the
//   pipeline comes up empty and ready. The data registers are not reset.
//   Stall: each stage holds its word while the next stage is full and
//   blocked; bubbles close up, so o_s_axis_tready only drops once all six
//   stages hold a word and the receiver keeps i_m_axis_tready low.
module hsv_to_rgb_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // hue[19:0], saturation[32:20], brightness[45:33], 0
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic                         w_front_vld;
    logic                         w_front_rdy;
    hsv_pkg::t_front              w_front;
    logic                         w_blend_vld;
    logic                         w_blend_rdy;
    hsv_pkg::t_blend              w_blend;
    logic [hsv_pkg::CHAN_W-1:0]   w_red;
    logic [hsv_pkg::CHAN_W-1:0]   w_green;
    logic [hsv_pkg::CHAN_W-1:0]   w_blue;

    hsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_hue        (i_s_axis_tdata[19:0]),
        .i_saturation (i_s_axis_tdata[32:20]),
        .i_brightness (i_s_axis_tdata[45:33]),
        .o_valid      (w_front_vld),
        .i_ready      (w_front_rdy),
        .o_front      (w_front)
    );

    hsv_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_vld),
        .o_ready (w_front_rdy),
        .i_front (w_front),
        .o_valid (w_blend_vld),
        .i_ready (w_blend_rdy),
        .o_blend (w_blend)
    );

    hsv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_blend_vld),
        .o_ready (w_blend_rdy),
        .i_blend (w_blend),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    assign o_m_axis_tdata = {w_blue, w_green, w_red};

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // input back-pressure only when the output is held up
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled with a free stage");

    // a full pipeline with a held output stays full, so input ready follows output ready
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_s_axis_tready && !i_m_axis_tready) |=> (o_s_axis_tready == i_m_axis_tready))
        else $error("full pipeline freed a stage without output transfer");

    // hold the output word steady while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output word changed while stalled");

endmodule

>>> sim/hsv_rgb_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the HSV to RGB converter: watches both stream channels,
// predicts each RGB word in fixed point and compares it. Uses hsv_pkg.
module hsv_rgb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,   // hue[19:0], saturation[32:20], brightness[45:33], 0
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // red[7:0], green[15:8], blue[23:16]
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int HUE_TURN  = 6 * hsv_pkg::SECTOR_SPAN;
    localparam int CHAN_MAX  = 255;
    localparam int MAX_SHOWN = 20;

    typedef struct packed {
        logic [hsv_pkg::HUE_W-1:0] hue;
        logic [hsv_pkg::Q12_W-1:0] sat;
        logic [hsv_pkg::Q12_W-1:0] bri;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
    } t_rgb_expect;

    t_rgb_expect rgb_expected[$];

    // floor(255 * num / (960 * 2^24)), held at full scale
    function automatic logic [7:0] channel_byte(input longint unsigned num);
        longint unsigned q;
        q = (num * CHAN_MAX) / (longint'(hsv_pkg::SECTOR_SPAN) << 24);
        if (q > CHAN_MAX)
            q = CHAN_MAX;
        return q[7:0];
    endfunction

    function automatic t_rgb_expect hsv_to_rgb_expected(
        input logic [hsv_pkg::HUE_W-1:0] hue,
        input logic [hsv_pkg::Q12_W-1:0] sat_raw,
        input logic [hsv_pkg::Q12_W-1:0] bri_raw);
        int                angle;
        hsv_pkg::t_sector  sector;
        longint unsigned   sat, bri, frac, top, base, ramp, rise, fall, r, g, b;
        t_rgb_expect       px;
        angle = $signed(hue);
        angle = angle % HUE_TURN;
        if (angle < 0)
            angle += HUE_TURN;
        sector = hsv_pkg::t_sector'(angle / hsv_pkg::SECTOR_SPAN);
        frac   = angle % hsv_pkg::SECTOR_SPAN;
        sat    = (sat_raw > hsv_pkg::Q_ONE) ? hsv_pkg::Q_ONE : sat_raw;
        bri    = (bri_raw > hsv_pkg::Q_ONE) ? hsv_pkg::Q_ONE : bri_raw;
        top    = bri * hsv_pkg::Q_ONE * hsv_pkg::SECTOR_SPAN;
        base   = bri * (hsv_pkg::Q_ONE - sat) * hsv_pkg::SECTOR_SPAN;
        ramp   = frac * bri * sat;
        rise   = base + ramp;
        fall   = top - ramp;
        case (sector)
            hsv_pkg::SEC_RED_YELLOW: begin
                r = top;  g = rise; b = base;
            end
            hsv_pkg::SEC_YELLOW_GREEN: begin
                r = fall; g = top;  b = base;
            end
            hsv_pkg::SEC_GREEN_CYAN: begin
                r = base; g = top;  b = rise;
            end
            hsv_pkg::SEC_CYAN_BLUE: begin
                r = base; g = fall; b = top;
            end
            hsv_pkg::SEC_BLUE_MAGENTA: begin
                r = rise; g = base; b = top;
            end
            default: begin
                r = top;  g = base; b = fall;
            end
        endcase
        px.hue   = hue;
        px.sat   = sat_raw;
        px.bri   = bri_raw;
        px.red   = channel_byte(r);
        px.green = channel_byte(g);
        px.blue  = channel_byte(b);
        return px;
    endfunction

    task automatic report_channel(input string name, input t_rgb_expect px,
                                  input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            o_errors++;
            if (o_errors <= MAX_SHOWN)
                $display("%0t: %s mismatch for hue %0d sat %0d bri %0d: expected %0d, got %0d",
                         $time, name, $signed(px.hue), px.sat, px.bri, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb_expect px;
        if (i_rst_n) begin
            // Check the outgoing word before queueing the incoming one
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (rgb_expected.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected RGB word %h, nothing pending", $time, i_m_tdata);
                end else begin
                    px = rgb_expected.pop_front();
                    o_pending--;
                    report_channel("red",   px, px.red,   i_m_tdata[7:0]);
                    report_channel("green", px, px.green, i_m_tdata[15:8]);
                    report_channel("blue",  px, px.blue,  i_m_tdata[23:16]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                rgb_expected.push_back(hsv_to_rgb_expected(i_s_tdata[19:0], i_s_tdata[32:20],
                                                           i_s_tdata[45:33]));
                o_pending++;
            end
        end
    end

endmodule

>>> sim/hsv_to_rgb_converter_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for hsv_to_rgb_converter_top: drives pixel words, stalls the
// RGB side at random, and gives the verdict. Depends on the top, hsv_pkg and hsv_rgb_checker.
module hsv_to_rgb_converter_top_tb;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_GAP      = 10;
    localparam int RANDOM_WORDS = 1150;
    localparam int BLOCKS       = 5;
    localparam int DRAIN_CYCLES = 24;       // well past the six-stage latency
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;               // hue[19:0], saturation[32:20], brightness[45:33], 0
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;                    // red[7:0], green[15:8], blue[23:16]

    int errors, pending, checked;
    int words_sent = 0;
    int cycle_count = 0;
    bit steady = 1'b0;                       // when set, neither side idles

    always #(CLK_HALF) i_clk = ~i_clk;

    hsv_to_rgb_converter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    hsv_rgb_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    // Idle cycles before the next word on either side; none in steady stretches
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one pixel word at a falling edge and hold it until it is taken.
    // Called at a falling edge, returns at a falling edge. A zero gap keeps
    // tvalid high so back-to-back words go in every cycle while s_tready is high.
    task automatic send_pixel(input int hue, input int sat, input int bri);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, bri[hsv_pkg::Q12_W-1:0], sat[hsv_pkg::Q12_W-1:0],
                     hue[hsv_pkg::HUE_W-1:0]};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every pending RGB word has come back
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // Saturation or brightness: mostly in range, some at the ends, some above 1.0
    function automatic int draw_q12();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(0, hsv_pkg::Q_ONE);
        else if (pick < 75)
            return $urandom_range(0, 1) ? hsv_pkg::Q_ONE : 0;
        else
            return $urandom_range(0, (1 << hsv_pkg::Q12_W) - 1);
    endfunction

    // Hue: full 20-bit range, with a share right on or beside a sector edge
    function automatic int draw_hue();
        int edge_hue;
        if ($urandom_range(0, 3) == 0) begin
            edge_hue = ($urandom_range(0, 12) * hsv_pkg::SECTOR_SPAN)
                       - 6 * hsv_pkg::SECTOR_SPAN + $urandom_range(0, 2) - 1;
            return edge_hue;
        end
        return $urandom_range(0, (1 << hsv_pkg::HUE_W) - 1);
    endfunction

    // Receiving side: stall a random number of cycles, then accept one word
    initial begin : rgb_sink
        int stall;
        wait (rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Watchdog: stop a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: primaries and secondaries at full scale, sector edges,
        // wrap from both sides, hue extremes, grey, black, held S and V.
        send_pixel(0,           hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(480,         hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(959,         hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(960,         hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(1920,        hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(2880,        hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(3840,        hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(4800,        hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(5759,        hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(5760,        2048,  hsv_pkg::Q_ONE);
        send_pixel(-1,          2048,  3000);
        send_pixel(-5760,       hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(-5761,       1000,  4000);
        send_pixel(-524288,     hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(524287,      hsv_pkg::Q_ONE, hsv_pkg::Q_ONE);
        send_pixel(1440,        0,     2048);
        send_pixel(2400,        hsv_pkg::Q_ONE, 0);
        send_pixel(3360,        0,     0);
        send_pixel(4320,        hsv_pkg::Q_ONE + 1, hsv_pkg::Q_ONE);
        send_pixel(5280,        2048,  hsv_pkg::Q_ONE + 1);
        send_pixel(-524288,     8191,  8191);
        send_pixel(524287,      8191,  1);
        send_pixel(-2000,       1,     8191);
        send_pixel(700,         4095,  4095);

        // Random blocks: the middle one runs without idling, and the pipeline
        // is drained empty before some of them
        for (int blk = 0; blk < BLOCKS; blk++) begin
            if (blk == 1 || blk == 3)
                drain_pipeline();
            steady = (blk == 2);
            for (int n = 0; n < RANDOM_WORDS / BLOCKS; n++)
                send_pixel(draw_hue(), draw_q12(), draw_q12());
        end
        steady = 1'b0;

        // Wait for the last RGB word, then watch a while for strays
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d pixel words sent over all six sectors, wrapped hues and held S/V,",
                 words_sent);
        $display("summary: %0d RGB words checked, %0d mismatches, %0d cycles",
                 checked, errors, cycle_count);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> hsv_to_rgb_converter_top.f
rtl/hsv_pkg.sv
rtl/hsv_front.sv
rtl/hsv_blend.sv
rtl/hsv_scale.sv
rtl/hsv_to_rgb_converter_top.sv
sim/hsv_rgb_checker.sv
sim/hsv_to_rgb_converter_top_tb.sv
